/* hw/rtl/ppts_pkg.sv */
`timescale 1ns / 1ps
package ppts_pkg;

    localparam int Q_BITS     = 48;
    localparam int DIV_STEPS  = 2;
    localparam int DIV_STAGES = Q_BITS / DIV_STEPS;
    localparam int DIM_BITS   = 14;
    localparam int AW         = 6;

    typedef enum logic [2:0] {
        REG_ROW_X_LO = 3'd0,
        REG_ROW_X_HI = 3'd1,
        REG_ROW_Y_LO = 3'd2,
        REG_ROW_Y_HI = 3'd3,
        REG_ROW_W_LO = 3'd4,
        REG_ROW_W_HI = 3'd5,
        REG_WIDTH    = 3'd6,
        REG_HEIGHT   = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic visible;
        logic neg_x;
        logic neg_y;
        logic ovf_x;
        logic ovf_y;
    } t_ctl;

endpackage

/* hw/rtl/ppts_div_stage.sv */
`timescale 1ns / 1ps
module ppts_div_stage
    import ppts_pkg::*;
#(
    parameter int RW = 52
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [RW-1:0]     i_w,
    input  logic [RW-1:0]     i_rem_x,
    input  logic [RW-1:0]     i_rem_y,
    input  logic [Q_BITS-1:0] i_q_x,
    input  logic [Q_BITS-1:0] i_q_y,
    input  logic [Q_BITS-1:0] i_n_x,
    input  logic [Q_BITS-1:0] i_n_y,
    input  t_ctl              i_ctl,
    output logic [RW-1:0]     o_w,
    output logic [RW-1:0]     o_rem_x,
    output logic [RW-1:0]     o_rem_y,
    output logic [Q_BITS-1:0] o_q_x,
    output logic [Q_BITS-1:0] o_q_y,
    output logic [Q_BITS-1:0] o_n_x,
    output logic [Q_BITS-1:0] o_n_y,
    output t_ctl              o_ctl
);

    logic [RW-1:0]     n_rem_x, n_rem_y;
    logic [Q_BITS-1:0] n_q_x, n_q_y, n_n_x, n_n_y;

    always_comb begin
        logic [RW:0] tx;
        logic [RW:0] ty;
        n_rem_x = i_rem_x;
        n_rem_y = i_rem_y;
        n_q_x   = i_q_x;
        n_q_y   = i_q_y;
        n_n_x   = i_n_x;
        n_n_y   = i_n_y;
        for (int s = 0; s < DIV_STEPS; s++) begin
            tx = {n_rem_x, n_n_x[Q_BITS-1]};
            ty = {n_rem_y, n_n_y[Q_BITS-1]};
            if (tx >= {1'b0, i_w}) begin
                tx    = tx - {1'b0, i_w};
                n_q_x = {n_q_x[Q_BITS-2:0], 1'b1};
            end else begin
                n_q_x = {n_q_x[Q_BITS-2:0], 1'b0};
            end
            if (ty >= {1'b0, i_w}) begin
                ty    = ty - {1'b0, i_w};
                n_q_y = {n_q_y[Q_BITS-2:0], 1'b1};
            end else begin
                n_q_y = {n_q_y[Q_BITS-2:0], 1'b0};
            end
            n_rem_x = tx[RW-1:0];
            n_rem_y = ty[RW-1:0];
            n_n_x   = {n_n_x[Q_BITS-2:0], 1'b0};
            n_n_y   = {n_n_y[Q_BITS-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_w     <= i_w;
            o_rem_x <= n_rem_x;
            o_rem_y <= n_rem_y;
            o_q_x   <= n_q_x;
            o_q_y   <= n_q_y;
            o_n_x   <= n_n_x;
            o_n_y   <= n_n_y;
            o_ctl   <= i_ctl;
        end
    end

endmodule

/* hw/rtl/perspective_project_to_screen_unit.sv */
`timescale 1ns / 1ps
// Projects one signed fixed-point 3-D point per transaction to screen pixels through the x, y
// and w rows of a view matrix held in the APB registers. The pipeline takes a new point in
// every clock cycle unless a stalled output has backed it up to its input. Its stages are, in
// order, multipliers, row sums, setup, a restoring divider that resolves two quotient bits per
// stage, pixel scaling and an output register. A stalled output holds only the stages behind
// it that are full, so bubbles are squeezed out before input is refused.
module perspective_project_to_screen_unit
    import ppts_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [AW-1:0]       paddr,
    input  logic [63:0]         pwdata,
    output logic [63:0]         prdata,
    output logic                pready,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic signed [31:0]  i_pos_x,
    input  logic signed [31:0]  i_pos_y,
    input  logic signed [31:0]  i_pos_z,
    output logic                o_valid,
    input  logic                i_ready,
    output logic                o_visible,
    output logic signed [31:0]  o_screen_x,
    output logic signed [31:0]  o_screen_y
);

    localparam int RW      = 68 - FRAC_BITS;
    localparam int SH      = Q_BITS - FRAC_BITS;
    localparam longint THRESH_I = ((longint'(1) << FRAC_BITS) + 50) / 100;
    localparam int ST_MUL  = DIV_STAGES + 3;
    localparam int NST     = DIV_STAGES + 5;

    logic [63:0]         r_row [6];
    logic [DIM_BITS-1:0] r_width, r_height;
    logic [NST-1:0]      r_v;
    logic [NST-1:0]      adv;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row[0] <= 64'd65536;
            r_row[1] <= 64'd0;
            r_row[2] <= 64'h0001_0000_0000_0000;
            r_row[3] <= 64'd0;
            r_row[4] <= 64'd0;
            r_row[5] <= 64'h0001_0000_0000_0000;
            r_width  <= DIM_BITS'(1920);
            r_height <= DIM_BITS'(1080);
        end else if (psel && penable && pwrite && pready) begin
            case (t_reg_idx'(paddr[5:3]))
                REG_WIDTH:  r_width  <= pwdata[DIM_BITS-1:0];
                REG_HEIGHT: r_height <= pwdata[DIM_BITS-1:0];
                default:    r_row[paddr[5:3]] <= pwdata;
            endcase
        end
    end

    always_comb begin
        case (t_reg_idx'(paddr[5:3]))
            REG_WIDTH:  prdata = 64'(r_width);
            REG_HEIGHT: prdata = 64'(r_height);
            default:    prdata = r_row[paddr[5:3]];
        endcase
    end

    always_comb begin
        adv[NST-1] = !r_v[NST-1] || i_ready;
        for (int k = NST - 2; k >= 0; k--) begin
            adv[k] = !r_v[k] || adv[k+1];
        end
    end

    assign o_ready = adv[0];
    assign o_valid = r_v[NST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (adv[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < NST; k++) begin
                if (adv[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    logic signed [31:0] coef [3][3];
    logic signed [31:0] trans [3];
    logic signed [31:0] pos [3];
    logic signed [63:0] r_prod [3][3];

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            coef[r][0] = r_row[2*r][31:0];
            coef[r][1] = r_row[2*r][63:32];
            coef[r][2] = r_row[2*r+1][31:0];
            trans[r]   = r_row[2*r+1][63:32];
        end
        pos[0] = i_pos_x;
        pos[1] = i_pos_y;
        pos[2] = i_pos_z;
    end

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_prod[r][c] <= coef[r][c] * pos[c];
                end
            end
        end
    end

    logic signed [65:0]   acc [3];
    logic signed [RW-1:0] r_sum [3];

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            acc[r] = 66'(r_prod[r][0]) + 66'(r_prod[r][1]) + 66'(r_prod[r][2]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[1]) begin
            for (int r = 0; r < 3; r++) begin
                r_sum[r] <= RW'((acc[r] >>> FRAC_BITS) + 66'(trans[r]));
            end
        end
    end

    logic [RW-1:0]      ax, ay, wu;
    logic [RW-1:0]      r_p_w, r_p_rem_x, r_p_rem_y;
    logic [Q_BITS-1:0]  r_p_n_x, r_p_n_y;
    t_ctl               r_p_ctl;
    logic [RW+FRAC_BITS-1:0] nx_full, ny_full;

    always_comb begin
        ax      = r_sum[0][RW-1] ? RW'(-r_sum[0]) : RW'(r_sum[0]);
        ay      = r_sum[1][RW-1] ? RW'(-r_sum[1]) : RW'(r_sum[1]);
        wu      = RW'(r_sum[2]);
        nx_full = {ax, FRAC_BITS'(0)};
        ny_full = {ay, FRAC_BITS'(0)};
    end

    always_ff @(posedge i_clk) begin
        if (adv[2]) begin
            r_p_w           <= wu;
            r_p_rem_x       <= ax >> SH;
            r_p_rem_y       <= ay >> SH;
            r_p_n_x         <= nx_full[Q_BITS-1:0];
            r_p_n_y         <= ny_full[Q_BITS-1:0];
            r_p_ctl.visible <= r_sum[2] >= $signed(RW'(THRESH_I));
            r_p_ctl.neg_x   <= r_sum[0][RW-1];
            r_p_ctl.neg_y   <= r_sum[1][RW-1];
            r_p_ctl.ovf_x   <= (RW+SH)'(ax) >= {wu, SH'(0)};
            r_p_ctl.ovf_y   <= (RW+SH)'(ay) >= {wu, SH'(0)};
        end
    end

    logic [RW-1:0]     d_w [DIV_STAGES+1];
    logic [RW-1:0]     d_rem_x [DIV_STAGES+1];
    logic [RW-1:0]     d_rem_y [DIV_STAGES+1];
    logic [Q_BITS-1:0] d_q_x [DIV_STAGES+1];
    logic [Q_BITS-1:0] d_q_y [DIV_STAGES+1];
    logic [Q_BITS-1:0] d_n_x [DIV_STAGES+1];
    logic [Q_BITS-1:0] d_n_y [DIV_STAGES+1];
    t_ctl              d_ctl [DIV_STAGES+1];

    assign d_w[0]     = r_p_w;
    assign d_rem_x[0] = r_p_rem_x;
    assign d_rem_y[0] = r_p_rem_y;
    assign d_q_x[0]   = '0;
    assign d_q_y[0]   = '0;
    assign d_n_x[0]   = r_p_n_x;
    assign d_n_y[0]   = r_p_n_y;
    assign d_ctl[0]   = r_p_ctl;

    for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
        ppts_div_stage #(
            .RW(RW)
        ) u_div (
            .i_clk   (i_clk),
            .i_en    (adv[3+j]),
            .i_w     (d_w[j]),
            .i_rem_x (d_rem_x[j]),
            .i_rem_y (d_rem_y[j]),
            .i_q_x   (d_q_x[j]),
            .i_q_y   (d_q_y[j]),
            .i_n_x   (d_n_x[j]),
            .i_n_y   (d_n_y[j]),
            .i_ctl   (d_ctl[j]),
            .o_w     (d_w[j+1]),
            .o_rem_x (d_rem_x[j+1]),
            .o_rem_y (d_rem_y[j+1]),
            .o_q_x   (d_q_x[j+1]),
            .o_q_y   (d_q_y[j+1]),
            .o_n_x   (d_n_x[j+1]),
            .o_n_y   (d_n_y[j+1]),
            .o_ctl   (d_ctl[j+1])
        );
    end

    logic [Q_BITS:0] qx, qy;
    logic [62:0]     mx, my;
    logic [61:0]     r_t_x, r_t_y;
    t_ctl            r_m_ctl;

    always_comb begin
        qx = d_ctl[DIV_STAGES].ovf_x ? (Q_BITS+1)'(1) << Q_BITS
                                     : {1'b0, d_q_x[DIV_STAGES]};
        qy = d_ctl[DIV_STAGES].ovf_y ? (Q_BITS+1)'(1) << Q_BITS
                                     : {1'b0, d_q_y[DIV_STAGES]};
        mx = 63'(qx) * 63'(r_width);
        my = 63'(qy) * 63'(r_height);
    end

    always_ff @(posedge i_clk) begin
        if (adv[ST_MUL]) begin
            r_t_x   <= mx[62:1];
            r_t_y   <= my[62:1];
            r_m_ctl <= d_ctl[DIV_STAGES];
        end
    end

    logic signed [64:0] tx_s, ty_s, sx, sy, half;
    logic signed [31:0] sx_sat, sy_sat;

    always_comb begin
        half   = 65'sd1 <<< (FRAC_BITS - 1);
        tx_s   = r_m_ctl.neg_x ? -$signed({3'b000, r_t_x}) : $signed({3'b000, r_t_x});
        ty_s   = r_m_ctl.neg_y ? -$signed({3'b000, r_t_y}) : $signed({3'b000, r_t_y});
        sx     = $signed(65'(r_width) << (FRAC_BITS - 1)) + tx_s + half;
        sy     = $signed(65'(r_height) << (FRAC_BITS - 1)) - (ty_s + half);
        sx_sat = (sx > 65'sh7FFF_FFFF) ? 32'sh7FFF_FFFF
               : (sx < -65'sh8000_0000) ? 32'sh8000_0000 : sx[31:0];
        sy_sat = (sy > 65'sh7FFF_FFFF) ? 32'sh7FFF_FFFF
               : (sy < -65'sh8000_0000) ? 32'sh8000_0000 : sy[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (adv[NST-1]) begin
            o_visible  <= r_m_ctl.visible;
            o_screen_x <= r_m_ctl.visible ? sx_sat : 32'sd0;
            o_screen_y <= r_m_ctl.visible ? sy_sat : 32'sd0;
        end
    end

`ifndef NO_ASSERTIONS
    a_hidden_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_visible |-> o_screen_x == 32'sd0 && o_screen_y == 32'sd0)
        else $error("Hidden point carries nonzero coordinates.");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("Output valid right after reset.");

    a_empty_ready: assert property (@(posedge i_clk)
        !o_valid |-> o_ready)
        else $error("Input refused while the output register is empty.");
`endif

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
    import ppts_pkg::*;

    localparam int FRAC = 16;
    localparam int LATENCY = 29;

    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
    } t_point;

    typedef struct packed {
        logic               vis;
        logic signed [31:0] sx;
        logic signed [31:0] sy;
    } t_pixel;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [AW-1:0] paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic pready;
    logic i_valid = 1'b0;
    logic o_ready;
    logic signed [31:0] i_pos_x = '0, i_pos_y = '0, i_pos_z = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic o_visible;
    logic signed [31:0] o_screen_x, o_screen_y;

    always #1 i_clk = ~i_clk;

    perspective_project_to_screen_unit #(.FRAC_BITS(FRAC)) u_dut (.*);

    logic [63:0] view_regs [8];
    t_point point_queue[$];
    t_pixel pixel_queue[$];
    int errors = 0;
    int burst_left = 0, gap_left = 0;
    int hold_cycles = 0;
    int stall_phase = 0;
    bit feed_open = 1'b0;

    function automatic longint signed sword(logic [31:0] w);
        return longint'(signed'(w));
    endfunction

    function automatic longint signed project_row(int row, t_point p);
        longint signed c0, c1, c2, tr, pr, hs, ls, h;
        longint signed pv[3];
        longint signed cv[3];
        c0 = sword(view_regs[row*2][31:0]);
        c1 = sword(view_regs[row*2][63:32]);
        c2 = sword(view_regs[row*2+1][31:0]);
        tr = sword(view_regs[row*2+1][63:32]);
        pv[0] = p.px; pv[1] = p.py; pv[2] = p.pz;
        cv[0] = c0; cv[1] = c1; cv[2] = c2;
        hs = 0; ls = 0;
        for (int i = 0; i < 3; i++) begin
            pr = cv[i] * pv[i];
            h = pr >>> FRAC;
            hs += h;
            ls += pr - (h <<< FRAC);
        end
        return hs + (ls >>> FRAC) + tr;
    endfunction

    function automatic longint signed ratio_scaled(longint signed r, longint signed w,
                                                   longint signed dim);
        logic [127:0] a, q;
        longint signed t;
        a = (r < 0) ? 128'(-r) : 128'(r);
        q = (a << FRAC) / 128'(w);
        if (q > (128'd1 << 48)) q = 128'd1 << 48;
        t = longint'((q * 128'(dim)) >> 1);
        return (r < 0) ? -t : t;
    endfunction

    function automatic logic [31:0] clamp32(longint signed v);
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        return v[31:0];
    endfunction

    function automatic t_pixel project_point(t_point p);
        longint signed rx, ry, rw, half, thr, wd, ht;
        t_pixel o;
        half = 64'sd1 <<< (FRAC - 1);
        thr = ((64'sd1 <<< FRAC) + 50) / 100;
        wd = longint'(view_regs[REG_WIDTH][13:0]);
        ht = longint'(view_regs[REG_HEIGHT][13:0]);
        rx = project_row(0, p);
        ry = project_row(1, p);
        rw = project_row(2, p);
        o = '0;
        if (rw >= thr) begin
            o.vis = 1'b1;
            o.sx = clamp32(wd * half + ratio_scaled(rx, rw, wd) + half);
            o.sy = clamp32(ht * half - (ratio_scaled(ry, rw, ht) + half));
        end
        return o;
    endfunction

    task automatic write_reg(t_reg_idx idx, logic [63:0] val);
        @(posedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= AW'(8 * int'(idx)); pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        view_regs[idx] = (idx >= REG_WIDTH) ? (val & 64'h3FFF) : val;
    endtask

    task automatic write_row(int row, logic [31:0] c0, logic [31:0] c1,
                             logic [31:0] c2, logic [31:0] tr);
        write_reg(t_reg_idx'(row * 2), {c1, c0});
        write_reg(t_reg_idx'(row * 2 + 1), {tr, c2});
    endtask

    task automatic drain();
        while (point_queue.size() != 0 || pixel_queue.size() != 0 || i_valid)
            @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
            2: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
            default: return 32'($signed($urandom_range(0, 2000 << 16)) - (1000 << 16));
        endcase
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || o_ready) begin
            if (i_valid && o_ready)
                pixel_queue.push_back(project_point({i_pos_x, i_pos_y, i_pos_z}));
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                i_valid <= 1'b0;
            end else if (feed_open && point_queue.size() != 0) begin
                t_point p;
                p = point_queue.pop_front();
                i_valid <= 1'b1;
                i_pos_x <= p.px; i_pos_y <= p.py; i_pos_z <= p.pz;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (pixel_queue.size() == 0) begin
                    $error("unexpected transaction");
                    errors++;
                end else begin
                    t_pixel e;
                    e = pixel_queue.pop_front();
                    if (o_visible !== e.vis) begin
                        $error("visible exp %0d got %0d", e.vis, o_visible); errors++;
                    end
                    if (o_screen_x !== e.sx) begin
                        $error("screen_x exp %0d got %0d", e.sx, o_screen_x); errors++;
                    end
                    if (o_screen_y !== e.sy) begin
                        $error("screen_y exp %0d got %0d", e.sy, o_screen_y); errors++;
                    end
                end
            end
            stall_phase <= (stall_phase + 1) % 97;
            if (hold_cycles > 0) begin
                hold_cycles <= hold_cycles - 1;
                i_ready <= 1'b0;
            end else if (stall_phase < 30) begin
                i_ready <= 1'b1;
            end else begin
                i_ready <= ($urandom_range(0, 3) != 0);
            end
        end
    end

    task automatic fill_random(int n);
        t_point p;
        repeat (n) begin
            p.px = rand_coord(); p.py = rand_coord(); p.pz = rand_coord();
            point_queue.push_back(p);
        end
    endtask

    initial begin
        t_point p;
        logic [31:0] one;
        one = 32'h0001_0000;
        view_regs[0] = 64'd65536; view_regs[1] = 0;
        view_regs[2] = 64'd281474976710656; view_regs[3] = 0;
        view_regs[4] = 0; view_regs[5] = 64'd281474976710656;
        view_regs[6] = 1920; view_regs[7] = 1080;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Directed points against the reset matrix (w is the translation, 1.0).
        p = '{32'sh7FFF_FFFF, 32'sh8000_0000, 0}; point_queue.push_back(p);
        p = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF}; point_queue.push_back(p);
        p = '{0, 0, 0}; point_queue.push_back(p);
        p = '{32'sh0000_8000, -32'sh0000_8000, 32'sh8000_0000}; point_queue.push_back(p);
        p = '{32'hFFFF_FFFF, 32'h0000_0001, 32'h5555_5555}; point_queue.push_back(p);
        p = '{32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA}; point_queue.push_back(p);
        feed_open = 1'b1;
        drain();

        // Perspective with w taken from z: near threshold, below it and tiny w.
        feed_open = 1'b0;
        write_row(2, 0, 0, one, 0);
        for (int z = 650; z <= 660; z++) begin
            p = '{one, -one, z}; point_queue.push_back(p);
        end
        p = '{32'sh7FFF_FFFF, 32'sh8000_0000, 656}; point_queue.push_back(p);
        p = '{one, one, -one}; point_queue.push_back(p);
        p = '{one, one, 32'sh8000_0000}; point_queue.push_back(p);
        p = '{one, one, 32'sh7FFF_FFFF}; point_queue.push_back(p);
        feed_open = 1'b1;
        drain();

        // Zero screen size, then a width of 8192 and the largest height.
        feed_open = 1'b0;
        write_reg(REG_WIDTH, 0);
        write_reg(REG_HEIGHT, 0);
        fill_random(6);
        feed_open = 1'b1;
        drain();
        feed_open = 1'b0;
        write_reg(REG_WIDTH, 64'd8192);
        write_reg(REG_HEIGHT, 64'hFFFF_FFFF_FFFF_3FFF);
        fill_random(6);
        feed_open = 1'b1;
        drain();

        // Long receiver hold-off while points keep coming.
        feed_open = 1'b0;
        write_reg(REG_WIDTH, 64'd640);
        write_reg(REG_HEIGHT, 64'd480);
        fill_random(150);
        hold_cycles = 300;
        feed_open = 1'b1;
        drain();

        // Random matrices, some extreme, each with a batch of random points.
        for (int ph = 0; ph < 12; ph++) begin
            feed_open = 1'b0;
            for (int r = 0; r < 6; r++) begin
                logic [63:0] v;
                case (ph % 4)
                    0: v = {$urandom(), $urandom()};
                    1: v = (ph[2]) ? 64'hFFFF_FFFF_FFFF_FFFF : 64'h7FFF_FFFF_8000_0000;
                    default: v = {32'($signed($urandom_range(0, 4 << 16)) - (2 << 16)),
                                  32'($signed($urandom_range(0, 4 << 16)) - (2 << 16))};
                endcase
                write_reg(t_reg_idx'(r), v);
            end
            if (ph % 3 == 0) write_reg(REG_ROW_W_HI, {32'($urandom_range(0, 8 << 16)),
                                                      view_regs[REG_ROW_W_HI][31:0]});
            write_reg(REG_WIDTH, (ph == 5) ? 64'd1 : 64'($urandom_range(1, 8192)));
            write_reg(REG_HEIGHT, (ph == 6) ? 64'd8192 : 64'($urandom_range(1, 8192)));
            fill_random(145);
            feed_open = 1'b1;
            drain();
        end

        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
